// ===== hw/rtl/stream_group_reverser_unit_macros.svh =====
// Assertion macros used by the checker of the group reverser.
// Needs nothing else; every macro takes a clock and an active-low reset.
`ifndef STREAM_GROUP_REVERSER_UNIT_MACROS_SVH
`define STREAM_GROUP_REVERSER_UNIT_MACROS_SVH

// same-cycle implication
`define SGR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SGR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sgr_pkg.sv =====
// Shared constants and controller/datapath command types of the group reverser.
// Depends on nothing.
`default_nettype none

package sgr_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned GS_W          = 7;
  localparam int unsigned MAX_GROUP_DEF = 64;
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;

  // register index, taken from paddr[2]
  localparam logic [0:0]      REG_GROUP_SIZE = 1'b0;
  localparam logic [GS_W-1:0] GS_RESET       = 7'd1;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic fill_clr;
    logic fill_inc;
    logic capture;
    logic cap_eos;
  } sgr_cmd_t;

  typedef struct packed {
    logic group_full;
    logic out_free;
  } sgr_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sgr_stream_if.sv =====
// Valid/ready stream interfaces for the input and result words.
// Depends on sgr_pkg for the data width.
`default_nettype none

interface sgr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sgr_pkg::DATA_W-1:0]   value;
  logic                                end_of_sequence;

  modport source (output valid, output value, output end_of_sequence, input ready);
  modport sink   (input valid, input value, input end_of_sequence, output ready);
endinterface

interface sgr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sgr_pkg::DATA_W-1:0]   value_res;
  logic                                end_of_sequence_res;

  modport source (output valid, output value_res, output end_of_sequence_res, input ready);
  modport sink   (input valid, input value_res, input end_of_sequence_res, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sgr_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none

module sgr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sgr_dp.sv =====
// Datapath: group_size register, fill count, group buffer and result register.
// Depends on sgr_pkg and sgr_ram.
`default_nettype none

module sgr_dp #(
  parameter int unsigned MAX_GROUP = sgr_pkg::MAX_GROUP_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire sgr_pkg::sgr_cmd_t                   cmd_i,
  input  wire logic [$clog2(MAX_GROUP)-1:0]        addr_i,
  output sgr_pkg::sgr_sts_t                        sts_o,
  output logic      [$clog2(MAX_GROUP)-1:0]        fill_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [sgr_pkg::GS_W-1:0]            cfg_wdata_i,
  output logic      [sgr_pkg::GS_W-1:0]            group_size_o,
  input  wire logic signed [sgr_pkg::DATA_W-1:0]   in_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [sgr_pkg::DATA_W-1:0]        out_value_o,
  output logic                                     out_eos_o
);

  localparam int unsigned AW = $clog2(MAX_GROUP);
  localparam int unsigned CW = $clog2(MAX_GROUP + 1);
  localparam int unsigned SW = (CW > sgr_pkg::GS_W) ? CW : sgr_pkg::GS_W;

  logic [sgr_pkg::GS_W-1:0]   gs_q;
  logic [AW-1:0]              fill_q, fill_d;
  logic                       out_valid_q, out_valid_d;
  logic [sgr_pkg::DATA_W-1:0] out_value_q;
  logic                       out_eos_q;
  logic [sgr_pkg::DATA_W-1:0] rdata;
  logic [SW-1:0]              k_raw, k_eff, n_cnt;

  sgr_ram #(
    .WIDTH (sgr_pkg::DATA_W),
    .DEPTH (MAX_GROUP)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .re_i    (cmd_i.rd_en),
    .addr_i  (addr_i),
    .wdata_i (in_value_i),
    .rdata_o (rdata)
  );

  // zero counts as one, anything above the buffer depth saturates
  always_comb begin
    k_raw = (gs_q == '0) ? SW'(1) : SW'(gs_q);
    k_eff = (k_raw > SW'(MAX_GROUP)) ? SW'(MAX_GROUP) : k_raw;
    n_cnt = SW'(fill_q) + SW'(1);
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.fill_clr) begin
      fill_d = '0;
    end else if (cmd_i.fill_inc) begin
      fill_d = fill_q + AW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.capture) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q        <= sgr_pkg::GS_RESET;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gs_q <= cfg_wdata_i;
      end
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      out_value_q <= rdata;
      out_eos_q   <= cmd_i.cap_eos;
    end
  end

  assign sts_o.group_full = (n_cnt >= k_eff);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign fill_o           = fill_q;
  assign group_size_o     = gs_q;
  assign out_valid_o      = out_valid_q;
  assign out_value_o      = out_value_q;
  assign out_eos_o        = out_eos_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sgr_ctrl.sv =====
// Controller: takes words into the buffer and sequences the drain of a group.
// Depends on sgr_pkg.
`default_nettype none

module sgr_ctrl #(
  parameter int unsigned MAX_GROUP = sgr_pkg::MAX_GROUP_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_eos_i,
  output logic                              in_ready_o,
  input  wire sgr_pkg::sgr_sts_t            sts_i,
  input  wire logic [$clog2(MAX_GROUP)-1:0] fill_i,
  output sgr_pkg::sgr_cmd_t                 cmd_o,
  output logic      [$clog2(MAX_GROUP)-1:0] addr_o
);

  localparam int unsigned AW = $clog2(MAX_GROUP);
  localparam int unsigned CW = $clog2(MAX_GROUP + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CAP
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          rev_q, rev_d;
  logic          last_q, last_d;
  logic          accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    cnt_d   = cnt_q;
    rev_d   = rev_q;
    last_d  = last_q;
    cmd_o   = '0;
    addr_o  = addr_q;
    unique case (state_q)
      ST_IDLE: begin
        addr_o      = fill_i;
        cmd_o.wr_en = accept;
        if (accept) begin
          if (sts_i.group_full) begin
            // full group: drain newest first
            cmd_o.fill_clr = 1'b1;
            state_d        = ST_RD;
            addr_d         = fill_i;
            cnt_d          = CW'(fill_i) + CW'(1);
            rev_d          = 1'b1;
            last_d         = in_eos_i;
          end else if (in_eos_i) begin
            // partial group closed by the end flag: drain in arrival order
            cmd_o.fill_clr = 1'b1;
            state_d        = ST_RD;
            addr_d         = '0;
            cnt_d          = CW'(fill_i) + CW'(1);
            rev_d          = 1'b0;
            last_d         = 1'b1;
          end else begin
            cmd_o.fill_inc = 1'b1;
          end
        end
      end
      ST_RD: begin
        // issue the read only once the result register is free
        if (sts_i.out_free) begin
          cmd_o.rd_en = 1'b1;
          addr_d      = rev_q ? (addr_q - AW'(1)) : (addr_q + AW'(1));
          cnt_d       = cnt_q - CW'(1);
          state_d     = ST_CAP;
        end
      end
      ST_CAP: begin
        cmd_o.capture = 1'b1;
        cmd_o.cap_eos = last_q && (cnt_q == '0);
        state_d       = (cnt_q == '0) ? ST_IDLE : ST_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      addr_q  <= '0;
      cnt_q   <= '0;
      rev_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
      rev_q   <= rev_d;
      last_q  <= last_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stream_group_reverser_unit.sv =====
// Stream group reverser. Words are gathered into groups of group_size (register 0, byte
// address 0, 1..64, 0 acts as 1, values above MAX_GROUP saturate). A full group leaves
// newest first as soon as its last word arrives; a trailing partial group closed by the
// end flag leaves in arrival order; the end flag rides on the last result of the sequence.
// Timing: an input word that does not close a group is written into the buffer. A group
// then drains one result at a time on the single-port buffer (read, then capture into
// the result register), and each read waits while an output stall holds the result
// register; input is held off during the drain. The buffer needs no clearing pass
// after reset.
// Depends on sgr_pkg, sgr_stream_if, sgr_ctrl, sgr_dp and sgr_ram.
`default_nettype none

module stream_group_reverser_unit #(
  parameter int unsigned MAX_GROUP = sgr_pkg::MAX_GROUP_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  sgr_in_if.sink                                 in_i,
  sgr_out_if.source                              out_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [sgr_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [sgr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [sgr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready
);

  localparam int unsigned AW = $clog2(MAX_GROUP);

  sgr_pkg::sgr_cmd_t        cmd;
  sgr_pkg::sgr_sts_t        sts;
  logic [AW-1:0]            addr;
  logic [AW-1:0]            fill;
  logic                     cfg_we;
  logic                     reg_sel;
  logic [sgr_pkg::GS_W-1:0] group_size;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == sgr_pkg::REG_GROUP_SIZE);
  assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? sgr_pkg::APB_DATA_W'(group_size) : '0;

  sgr_ctrl #(
    .MAX_GROUP (MAX_GROUP)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_eos_i   (in_i.end_of_sequence),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .fill_i     (fill),
    .cmd_o      (cmd),
    .addr_o     (addr)
  );

  sgr_dp #(
    .MAX_GROUP (MAX_GROUP)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .addr_i       (addr),
    .sts_o        (sts),
    .fill_o       (fill),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (pwdata[sgr_pkg::GS_W-1:0]),
    .group_size_o (group_size),
    .in_value_i   (in_i.value),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_value_o  (out_o.value_res),
    .out_eos_o    (out_o.end_of_sequence_res)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/sgr_checker.sv =====
// Port-level checker for the group reverser, bound to the top level.
// Depends on sgr_pkg and the assertion macro header.
`default_nettype none
`include "stream_group_reverser_unit_macros.svh"

module sgr_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_i,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic [sgr_pkg::DATA_W-1:0]        out_value_i,
  input wire logic                              out_eos_i,
  input wire logic                              psel_i,
  input wire logic                              penable_i,
  input wire logic                              pwrite_i,
  input wire logic [sgr_pkg::APB_ADDR_W-1:0]    paddr_i,
  input wire logic [sgr_pkg::APB_DATA_W-1:0]    pwdata_i,
  input wire logic [sgr_pkg::APB_DATA_W-1:0]    prdata_i
);

  // words taken in but not yet handed out
  logic [15:0] pend_q;
  logic        in_acc, out_acc, cfg_wr;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign cfg_wr  = psel_i && penable_i && pwrite_i && (paddr_i[2] == sgr_pkg::REG_GROUP_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 16'(in_acc) - 16'(out_acc);
    end
  end

  `SGR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_value_i) && $stable(out_eos_i), "result word dropped or changed")

  `SGR_ASSERT_NOW(a_out_has_src, clk_i, rst_ni, out_valid_i, pend_q != '0,
    "result word without a held input word")

  `SGR_ASSERT_NOW(a_stall_drain, clk_i, rst_ni, !in_ready_i, pend_q != '0,
    "input stalled with nothing to drain")

  `SGR_ASSERT_NOW(a_cfg_readback, clk_i, rst_ni,
    cfg_wr ##1 (paddr_i[2] == sgr_pkg::REG_GROUP_SIZE),
    prdata_i[sgr_pkg::GS_W-1:0] == $past(pwdata_i[sgr_pkg::GS_W-1:0], 1),
    "group_size read-back differs from last write")

endmodule

bind stream_group_reverser_unit sgr_checker u_sgr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.value_res),
  .out_eos_i   (out_o.end_of_sequence_res),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);

`default_nettype wire

// ===== tb/stream_group_reverser_unit_tb.sv =====
// Testbench for the stream group reverser: directed table, then random phases of sequences.
// Checks result words against the table or a group-reversal predictor; reads back the register.
// Depends on sgr_pkg, sgr_stream_if and stream_group_reverser_unit.
`timescale 1ns / 1ps

module stream_group_reverser_unit_tb;

  localparam int unsigned MAX_GROUP    = sgr_pkg::MAX_GROUP_DEF;
  localparam int unsigned RANDOM_WORDS = 480;
  localparam int unsigned SETTLE_CYC   = 8;
  localparam int unsigned IDLE_PCT     = 17;
  localparam int unsigned EXP_DEPTH    = 256;

  localparam logic [sgr_pkg::APB_ADDR_W-1:0] ADDR_GROUP_SIZE = {sgr_pkg::REG_GROUP_SIZE, 2'b00};
  localparam logic [sgr_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED   = 3'd4;

  typedef struct packed {
    logic [sgr_pkg::DATA_W-1:0] value;
    logic                       eos;
  } sgr_result_t;

  typedef enum logic [0:0] {ROW_WORD, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [sgr_pkg::APB_ADDR_W-1:0] addr;
    logic [sgr_pkg::DATA_W-1:0]     data;
    logic                           eos;
    logic                           typed;
    logic [sgr_pkg::DATA_W-1:0]     exp_value;
    logic                           exp_eos;
  } dir_row_t;

  localparam int unsigned N_ROWS = 25;
  localparam dir_row_t DIRECTED [N_ROWS] = '{
    // group size 1 after reset: straight through
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1},
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{ROW_WRITE, ADDR_GROUP_SIZE, 32'd3,         1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'd1,         1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'd2,         1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'd3,         1'b0, 1'b0, '0, 1'b0},
    // partial group closed by the end flag
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'd4,         1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'd5,         1'b1, 1'b0, '0, 1'b0},
    // end flag on the word that fills the group
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'd6,         1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'd7,         1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'd8,         1'b1, 1'b0, '0, 1'b0},
    // two held, then the size drops to the number held
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'd9,         1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'd10,        1'b0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, ADDR_GROUP_SIZE, 32'd2,         1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'd11,        1'b0, 1'b0, '0, 1'b0},
    // unmapped register: must not touch the size
    '{ROW_WRITE, ADDR_UNMAPPED,   32'd5,         1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'd12,        1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'd13,        1'b0, 1'b0, '0, 1'b0},
    // size zero acts as one
    '{ROW_WRITE, ADDR_GROUP_SIZE, 32'hFFFF_FF80, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'd14,        1'b0, 1'b0, '0, 1'b0},
    // size above the buffer saturates
    '{ROW_WRITE, ADDR_GROUP_SIZE, 32'h0000_007F, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'd15,        1'b1, 1'b0, '0, 1'b0},
    '{ROW_WORD,  ADDR_GROUP_SIZE, 32'd16,        1'b0, 1'b0, '0, 1'b0}
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [sgr_pkg::APB_ADDR_W-1:0] paddr;
  logic [sgr_pkg::APB_DATA_W-1:0] pwdata;
  logic [sgr_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  sgr_in_if  in_if ();
  sgr_out_if out_if ();

  stream_group_reverser_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [sgr_pkg::DATA_W-1:0] held_words [MAX_GROUP];
  int unsigned                held_count;
  logic [sgr_pkg::GS_W-1:0]   size_reg;

  // expected result words, written by the predictor, read by the checker
  sgr_result_t exp_mem [EXP_DEPTH];
  int unsigned exp_wr;
  int unsigned exp_rd;

  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned reg_writes;
  bit          steady;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // no idling on either side for a stretch of words in the middle
  assign steady = (words_sent >= 150) && (words_sent < 270);

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned exp_level();
    return exp_wr - exp_rd;
  endfunction

  task automatic add_expected(input logic [sgr_pkg::DATA_W-1:0] value, input logic eos);
    if (exp_level() >= EXP_DEPTH) begin
      report_mismatch("expected word store overflow");
    end else begin
      exp_mem[exp_wr % EXP_DEPTH] = '{value, eos};
      exp_wr++;
    end
  endtask

  function automatic int unsigned active_size();
    if (size_reg == 0) return 1;
    if (size_reg > MAX_GROUP) return MAX_GROUP;
    return 32'(size_reg);
  endfunction

  // record = 0 updates the state only; the caller queues its own result
  task automatic predict_word(input logic [sgr_pkg::DATA_W-1:0] value, input logic eos,
                              input bit record);
    int unsigned k;
    int unsigned n;
    k = active_size();
    if (held_count >= MAX_GROUP) held_count = MAX_GROUP - 1;
    held_words[held_count] = value;
    held_count++;
    n = held_count;
    if (n >= k) begin
      for (int unsigned i = 0; i < n; i++)
        if (record) add_expected(held_words[n-1-i], eos && (i == n-1));
      held_count = 0;
    end else if (eos) begin
      for (int unsigned i = 0; i < n; i++)
        if (record) add_expected(held_words[i], i == n-1);
      held_count = 0;
    end
  endtask

  task automatic send_word(input logic [sgr_pkg::DATA_W-1:0] value, input logic eos);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid           = 1'b1;
    in_if.value           = value;
    in_if.end_of_sequence = eos;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
  endtask

  // hold the stream off until every expected result is out and the block has settled
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (exp_level() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  // write, then read the size back over a second transfer
  task automatic write_register(input logic [sgr_pkg::APB_ADDR_W-1:0] addr,
                                input logic [sgr_pkg::APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_GROUP_SIZE) size_reg = data[sgr_pkg::GS_W-1:0];
    reg_writes++;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ADDR_GROUP_SIZE;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[sgr_pkg::GS_W-1:0] !== size_reg)
      report_mismatch($sformatf("group_size reads %0d, expected %0d",
                                prdata[sgr_pkg::GS_W-1:0], size_reg));
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin : check_results
    sgr_result_t head;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (exp_level() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", out_if.value_res));
      end else begin
        head = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        results_seen++;
        if (out_if.value_res !== head.value)
          report_mismatch($sformatf("value_res %h, expected %h",
                                    out_if.value_res, head.value));
        if (out_if.end_of_sequence_res !== head.eos)
          report_mismatch($sformatf("end_of_sequence_res %b, expected %b",
                                    out_if.end_of_sequence_res, head.eos));
      end
    end
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", exp_level());
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned                random_words;
    int unsigned                k;
    int unsigned                seq_count;
    int unsigned                seq_len;
    int unsigned                pick;
    int unsigned                guard;
    bit                         closed;
    logic [sgr_pkg::GS_W-1:0]   new_size;
    logic [sgr_pkg::DATA_W-1:0] wr_data;
    logic [sgr_pkg::DATA_W-1:0] value;
    logic                       eos;

    in_if.valid           = 1'b0;
    in_if.value           = '0;
    in_if.end_of_sequence = 1'b0;
    out_if.ready          = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    rst_ni                = 1'b0;
    held_count            = 0;
    size_reg              = sgr_pkg::GS_RESET;
    exp_wr                = 0;
    exp_rd                = 0;
    mismatches            = 0;
    words_sent            = 0;
    results_seen          = 0;
    reg_writes            = 0;
    random_words          = 0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int unsigned r = 0; r < N_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        wait_drained();
        write_register(DIRECTED[r].addr, DIRECTED[r].data);
      end else begin
        send_word(DIRECTED[r].data, DIRECTED[r].eos);
        predict_word(DIRECTED[r].data, DIRECTED[r].eos, !DIRECTED[r].typed);
        if (DIRECTED[r].typed)
          add_expected(DIRECTED[r].exp_value, DIRECTED[r].exp_eos);
      end
    end

    // random phases: one register setting each, then a few sequences
    while (random_words < RANDOM_WORDS) begin
      wait_drained();
      pick = $urandom_range(0, 19);
      case (pick)
        0:       new_size = '0;
        1:       new_size = '1;
        2:       new_size = sgr_pkg::GS_W'(MAX_GROUP);
        3:       new_size = sgr_pkg::GS_W'($urandom_range(MAX_GROUP + 1, 126));
        4, 5:    new_size = sgr_pkg::GS_W'(1);
        6:       new_size = sgr_pkg::GS_W'($urandom_range(9, 24));
        default: new_size = sgr_pkg::GS_W'($urandom_range(2, 8));
      endcase
      if ($urandom_range(0, 3) == 0) write_register(ADDR_UNMAPPED, $urandom());
      wr_data                    = $urandom();
      wr_data[sgr_pkg::GS_W-1:0] = new_size;
      write_register(ADDR_GROUP_SIZE, wr_data);
      k = active_size();

      seq_count = $urandom_range(1, 3);
      for (int unsigned s = 0; s < seq_count; s++) begin
        seq_len = k * ((k >= 16) ? $urandom_range(0, 1) : $urandom_range(0, 4))
                  + $urandom_range(0, k - 1);
        if (seq_len == 0) seq_len = k;
        // an unclosed sequence leaves a part group held across the next write
        closed = ($urandom_range(0, 6) != 0);
        for (int unsigned j = 0; j < seq_len; j++) begin
          case ($urandom_range(0, 15))
            0:       value = 32'h7FFF_FFFF;
            1:       value = 32'h8000_0000;
            2:       value = '0;
            3:       value = '1;
            default: value = $urandom();
          endcase
          eos = ((j == seq_len - 1) && closed) || ($urandom_range(0, 29) == 0);
          send_word(value, eos);
          predict_word(value, eos, 1'b1);
          random_words++;
        end
      end
    end

    @(negedge clk_i);
    in_if.valid = 1'b0;
    guard = 0;
    while (exp_level() != 0 && guard < 50000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4 * SETTLE_CYC) @(posedge clk_i);
    while (exp_level() != 0) begin
      exp_rd++;
      report_mismatch("expected result word never arrived");
    end

    $display("Sent %0d words over %0d register writes, group sizes 0 to 127 included",
             words_sent, reg_writes);
    $display("Checked %0d result words, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
